// File: design/c2s_pkg.sv
`default_nettype none

package c2s_pkg;

    // field widths
    localparam int COORD_W = 18;
    localparam int RAD_W   = 18;
    localparam int THETA_W = 16;
    localparam int PHI_W   = 17;

    // front end
    localparam int SQ_W      = 2 * COORD_W - 1;   // one square, up to 2^34
    localparam int SUM_W     = SQ_W + 1;          // sum of squares
    localparam int RHO_SHIFT = 20;                // rho gets 10 fraction bits
    localparam int RHO_IN_W  = SUM_W + RHO_SHIFT;
    localparam int RHO_W     = RHO_IN_W / 2;
    localparam int Z_SHIFT   = 10;                // z on the rho scale

    // angle unit
    localparam int ANG_IN_W = 29;                 // signed operands of the angle unit
    localparam int NORM_W   = 41;                 // normalized magnitude in [2^40, 2^41)
    localparam int NSH      = 6;                  // shift steps 32,16,8,4,2,1
    localparam int CW       = 44;                 // rotation datapath
    localparam int ZW       = 44;                 // angle accumulator, rad * 2^40
    localparam int ITER     = 40;
    localparam int FRAC     = 40;
    localparam int U_SHIFT  = 8;
    localparam int U_W      = 33;                 // clamped angle, rad * 2^32
    localparam int INV_PI_W = 30;
    localparam longint INV_PI = 683565276;        // round(2^31 / pi)
    localparam int PROD_W   = U_W + INV_PI_W;
    localparam int RND_W    = PROD_W + 1;
    localparam int RND_POS  = 48;
    localparam int QF_W     = RND_W - RND_POS;
    localparam int Q_W      = 15;
    localparam int Q_MAX    = 16384;              // quarter turn
    localparam int HALF_TURN = 32768;

    localparam longint ONE_Q = longint'(1) << FRAC;

    // floor(num / den) by shift and subtract, nonnegative operands; table build only
    function automatic longint udiv(input longint num, input longint den);
        longint quo;
        longint r;
        quo = 0;
        r   = 0;
        for (int b = 62; b >= 0; b--) begin
            r = (r << 1) | ((num >>> b) & longint'(1));
            if (r >= den) begin
                r   = r - den;
                quo = quo | (longint'(1) << b);
            end
        end
        return quo;
    endfunction

    // atan(2^-sh) * 2^40 by the truncated odd series
    function automatic longint atan_pow2(input int sh);
        longint p;
        longint sum;
        longint term;
        bit     done;
        p    = ONE_Q >>> sh;
        sum  = p;
        done = 1'b0;
        for (int k = 1; k < 64; k++) begin
            if (!done) begin
                p = p >>> (2 * sh);
                if (p == 0) begin
                    done = 1'b1;
                end
                else begin
                    term = udiv(p, longint'(2 * k + 1));
                    if ((k & 1) != 0) begin
                        sum = sum - term;
                    end
                    else begin
                        sum = sum + term;
                    end
                end
            end
        end
        return sum;
    endfunction

    // atan(1/3) * 2^40, same series
    function automatic longint atan_third();
        longint p;
        longint sum;
        longint term;
        bit     done;
        p    = udiv(ONE_Q, longint'(3));
        sum  = p;
        done = 1'b0;
        for (int k = 1; k < 64; k++) begin
            if (!done) begin
                p = udiv(p, longint'(9));
                if (p == 0) begin
                    done = 1'b1;
                end
                else begin
                    term = udiv(p, longint'(2 * k + 1));
                    if ((k & 1) != 0) begin
                        sum = sum - term;
                    end
                    else begin
                        sum = sum + term;
                    end
                end
            end
        end
        return sum;
    endfunction

    // rotation angle table; entry 0 is atan(1/2) + atan(1/3) = pi/4
    function automatic longint atan_entry(input int idx);
        if (idx == 0) begin
            return atan_pow2(1) + atan_third();
        end
        return atan_pow2(idx);
    endfunction

endpackage

`default_nettype wire

// File: design/c2s_isqrt.sv
`default_nettype none

module c2s_isqrt #(
    parameter int IN_W   = 36,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     radicand,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   root,
    output logic [IN_W/2:0]     rem,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int R = IN_W / 2;

    logic [R-1:0]      root_reg [R];
    logic [R:0]        rem_reg  [R];
    logic [IN_W-1:0]   val_reg  [R];
    logic [SIDE_W-1:0] side_reg [R];
    logic              vld_reg  [R];

    // one result bit per stage
    for (genvar j = 0; j < R; j++) begin : g_st
        logic [R-1:0]      p_root;
        logic [R:0]        p_rem;
        logic [IN_W-1:0]   p_val;
        logic [SIDE_W-1:0] p_side;
        logic              p_vld;
        logic [R+2:0]      cur;
        logic [R+2:0]      trial;
        logic [R+2:0]      diff;
        logic              ge;

        if (j == 0) begin : g_first
            assign p_root = '0;
            assign p_rem  = '0;
            assign p_val  = radicand;
            assign p_side = in_side;
            assign p_vld  = in_valid;
        end
        else begin : g_next
            assign p_root = root_reg[j-1];
            assign p_rem  = rem_reg[j-1];
            assign p_val  = val_reg[j-1];
            assign p_side = side_reg[j-1];
            assign p_vld  = vld_reg[j-1];
        end

        assign cur   = {p_rem, p_val[IN_W-1 -: 2]};
        assign trial = {1'b0, p_root, 2'b01};
        assign diff  = cur - trial;
        assign ge    = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[j] <= 1'b0;
            end
            else if (en) begin
                vld_reg[j] <= p_vld;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                root_reg[j] <= {p_root[R-2:0], ge};
                rem_reg[j]  <= ge ? diff[R:0] : cur[R:0];
                val_reg[j]  <= {p_val[IN_W-3:0], 2'b00};
                side_reg[j] <= p_side;
            end
        end
    end

    assign out_valid = vld_reg[R-1];
    assign root      = root_reg[R-1];
    assign rem       = rem_reg[R-1];
    assign out_side  = side_reg[R-1];

endmodule

`default_nettype wire

// File: design/c2s_cordic.sv
`default_nettype none

module c2s_cordic
    import c2s_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [ANG_IN_W-1:0] a,
    input  logic signed [ANG_IN_W-1:0] b,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic signed [PHI_W-1:0]    angle,
    output logic [SIDE_W-1:0]          out_side
);

    // abs/max, normalize, rotations, clamp, scale, round+quadrant
    localparam int STAGES = NSH + ITER + 4;
    localparam int CAR_W  = SIDE_W + 3;
    localparam logic signed [ZW-1:0] LIM = ZW'(2 * atan_entry(0));
    localparam logic [INV_PI_W-1:0] INV_PI_C = INV_PI_W'(INV_PI);
    localparam logic [RND_W-1:0] HALF_RND = RND_W'(1) << (RND_POS - 1);
    localparam logic signed [PHI_W-1:0] HALF_C = PHI_W'(HALF_TURN);

    logic              vld_reg [STAGES];
    logic [CAR_W-1:0]  car_reg [STAGES];

    logic [NORM_W-1:0] ua_reg [NSH+1];
    logic [NORM_W-1:0] ub_reg [NSH+1];
    logic [NORM_W-1:0] m_reg  [NSH+1];

    logic signed [CW-1:0] x_reg [ITER];
    logic signed [CW-1:0] y_reg [ITER];
    logic signed [ZW-1:0] z_reg [ITER];

    logic [U_W-1:0]          u_reg;
    logic [PROD_W-1:0]       p_reg;
    logic signed [PHI_W-1:0] res_reg;

    // sign/zero flags and side data ride alongside
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en) begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < STAGES; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // magnitudes
    logic                a_neg;
    logic                b_neg;
    logic [ANG_IN_W-1:0] a_mag;
    logic [ANG_IN_W-1:0] b_mag;
    logic [NORM_W-1:0]   ua0;
    logic [NORM_W-1:0]   ub0;
    logic [NORM_W-1:0]   m0;

    assign a_neg = a[ANG_IN_W-1];
    assign b_neg = b[ANG_IN_W-1];
    assign a_mag = a_neg ? ANG_IN_W'(-a) : ANG_IN_W'(a);
    assign b_mag = b_neg ? ANG_IN_W'(-b) : ANG_IN_W'(b);
    assign ua0   = {{(NORM_W-ANG_IN_W){1'b0}}, a_mag};
    assign ub0   = {{(NORM_W-ANG_IN_W){1'b0}}, b_mag};
    assign m0    = (ua0 > ub0) ? ua0 : ub0;

    always_ff @(posedge clk) begin
        if (en) begin
            car_reg[0] <= {in_side, (m0 == '0), a_neg, b_neg};
            for (int k = 1; k < STAGES; k++) begin
                car_reg[k] <= car_reg[k-1];
            end
            ua_reg[0] <= ua0;
            ub_reg[0] <= ub0;
            m_reg[0]  <= m0;
        end
    end

    // normalize: larger magnitude into [2^40, 2^41)
    for (genvar k = 0; k < NSH; k++) begin : g_norm
        localparam int AMT = 1 << (NSH - 1 - k);
        localparam logic [NORM_W-1:0] THR = NORM_W'(1) << (NORM_W - AMT);
        logic sh;
        assign sh = (m_reg[k] < THR);

        always_ff @(posedge clk) begin
            if (en) begin
                ua_reg[k+1] <= sh ? (ua_reg[k] << AMT) : ua_reg[k];
                ub_reg[k+1] <= sh ? (ub_reg[k] << AMT) : ub_reg[k];
                m_reg[k+1]  <= sh ? (m_reg[k] << AMT) : m_reg[k];
            end
        end
    end

    // vectoring rotations, one per stage
    for (genvar i = 0; i < ITER; i++) begin : g_rot
        localparam logic signed [ZW-1:0] ATAN_I = ZW'(atan_entry(i));
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [ZW-1:0] pz;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        if (i == 0) begin : g_first
            assign px = signed'({{(CW-NORM_W){1'b0}}, ua_reg[NSH]});
            assign py = signed'({{(CW-NORM_W){1'b0}}, ub_reg[NSH]});
            assign pz = '0;
        end
        else begin : g_next
            assign px = x_reg[i-1];
            assign py = y_reg[i-1];
            assign pz = z_reg[i-1];
        end

        assign dx = py >>> i;
        assign dy = px >>> i;

        always_ff @(posedge clk) begin
            if (en) begin
                if (!py[CW-1]) begin
                    x_reg[i] <= px + dx;
                    y_reg[i] <= py - dy;
                    z_reg[i] <= pz + ATAN_I;
                end
                else begin
                    x_reg[i] <= px - dx;
                    y_reg[i] <= py + dy;
                    z_reg[i] <= pz - ATAN_I;
                end
            end
        end
    end

    // clamp to [0, pi/2], drop to rad * 2^32
    logic signed [ZW-1:0] zf;
    logic signed [ZW-1:0] zc;
    assign zf = z_reg[ITER-1];
    assign zc = zf[ZW-1] ? '0 : ((zf > LIM) ? LIM : zf);

    // round at bit 48, clamp, unfold quadrant
    logic [CAR_W-1:0]        fl;
    logic [RND_W-1:0]        rnd;
    logic [QF_W-1:0]         qf;
    logic [Q_W-1:0]          q;
    logic signed [PHI_W-1:0] qs;
    logic signed [PHI_W-1:0] res_next;

    assign fl  = car_reg[STAGES-2];
    assign rnd = {1'b0, p_reg} + HALF_RND;
    assign qf  = rnd[RND_W-1:RND_POS];
    assign q   = fl[2] ? '0 :
                 ((qf > QF_W'(Q_MAX)) ? Q_W'(Q_MAX) : qf[Q_W-1:0]);
    assign qs  = signed'({{(PHI_W-Q_W){1'b0}}, q});

    always_comb begin
        case ({fl[1], fl[0]})
            2'b00:   res_next = qs;
            2'b01:   res_next = -qs;
            2'b10:   res_next = HALF_C - qs;
            2'b11:   res_next = qs - HALF_C;
            default: res_next = qs;
        endcase
    end

    always_ff @(posedge clk) begin
        if (en) begin
            u_reg   <= zc[U_SHIFT +: U_W];
            p_reg   <= PROD_W'(u_reg) * PROD_W'(INV_PI_C);
            res_reg <= res_next;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign angle     = res_reg;
    assign out_side  = car_reg[STAGES-1][CAR_W-1:3];

endmodule

`default_nettype wire

// File: design/cartesian_to_spherical_core.sv
// Cartesian to spherical conversion, fully pipelined.
// Throughput: one point per cycle; the whole pipe freezes while out_stall holds a beat.
// The depth is set by the two bit-per-stage square roots and the 40 rotation stages.
// Reset (rst_n, async, active low) empties every stage; data registers are not cleared.
`default_nettype none

module cartesian_to_spherical_core
    import c2s_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [RAD_W-1:0]          radius,
    output logic [THETA_W-1:0]        polar_angle,
    output logic signed [PHI_W-1:0]   azimuth
);

    // Global advance: every stage moves when the output register is free
    // or is being drained this cycle.
    logic en;
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    // ---------------------------------------------------------------
    // Stage A: capture the input beat
    // ---------------------------------------------------------------
    logic                      va_reg;
    logic signed [COORD_W-1:0] xa_reg;
    logic signed [COORD_W-1:0] ya_reg;
    logic signed [COORD_W-1:0] za_reg;

    // ---------------------------------------------------------------
    // Stage B: three 18x18 squares, all nonnegative
    // ---------------------------------------------------------------
    logic                      vb_reg;
    logic signed [COORD_W-1:0] xb_reg;
    logic signed [COORD_W-1:0] yb_reg;
    logic signed [COORD_W-1:0] zb_reg;
    logic [SQ_W-1:0]           x2_reg;
    logic [SQ_W-1:0]           y2_reg;
    logic [SQ_W-1:0]           z2_reg;
    logic signed [2*COORD_W-1:0] xsq;
    logic signed [2*COORD_W-1:0] ysq;
    logic signed [2*COORD_W-1:0] zsq;

    assign xsq = xa_reg * xa_reg;
    assign ysq = ya_reg * ya_reg;
    assign zsq = za_reg * za_reg;

    // ---------------------------------------------------------------
    // Stage C: x^2+y^2 (for rho) and the full sum (for the radius)
    // ---------------------------------------------------------------
    logic                      vc_reg;
    logic signed [COORD_W-1:0] xc_reg;
    logic signed [COORD_W-1:0] yc_reg;
    logic signed [COORD_W-1:0] zc_reg;
    logic [SUM_W-1:0]          pxy_reg;
    logic [SUM_W-1:0]          s_reg;
    logic [SUM_W-1:0]          pxy_next;

    assign pxy_next = {1'b0, x2_reg} + {1'b0, y2_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            xa_reg  <= coord_x;
            ya_reg  <= coord_y;
            za_reg  <= coord_z;
            xb_reg  <= xa_reg;
            yb_reg  <= ya_reg;
            zb_reg  <= za_reg;
            x2_reg  <= xsq[SQ_W-1:0];
            y2_reg  <= ysq[SQ_W-1:0];
            z2_reg  <= zsq[SQ_W-1:0];
            xc_reg  <= xb_reg;
            yc_reg  <= yb_reg;
            zc_reg  <= zb_reg;
            pxy_reg <= pxy_next;
            s_reg   <= pxy_next + {1'b0, z2_reg};
        end
    end

    // ---------------------------------------------------------------
    // Radius: 18-stage integer square root, coordinates ride along
    // ---------------------------------------------------------------
    localparam int SQ_SIDE_W = 3 * COORD_W + SUM_W;

    logic                      sq_valid;
    logic [RAD_W-1:0]          sq_root;
    logic [RAD_W:0]            sq_rem;
    logic [SQ_SIDE_W-1:0]      sq_side;
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] zs;
    logic [SUM_W-1:0]          pxys;

    c2s_isqrt #(
        .IN_W   (SUM_W),
        .SIDE_W (SQ_SIDE_W)
    ) u_rad_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vc_reg),
        .radicand  (s_reg),
        .in_side   ({xc_reg, yc_reg, zc_reg, pxy_reg}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .rem       (sq_rem),
        .out_side  (sq_side)
    );

    assign {xs, ys, zs, pxys} = sq_side;

    // ---------------------------------------------------------------
    // Stage D: round to nearest; s - f^2 > f bumps the floor root.
    // A tie is impossible for integer s.
    // ---------------------------------------------------------------
    logic                      vd_reg;
    logic signed [COORD_W-1:0] xd_reg;
    logic signed [COORD_W-1:0] yd_reg;
    logic signed [COORD_W-1:0] zd_reg;
    logic [SUM_W-1:0]          pxyd_reg;
    logic [RAD_W-1:0]          rd_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vd_reg <= 1'b0;
        end
        else if (en) begin
            vd_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            xd_reg   <= xs;
            yd_reg   <= ys;
            zd_reg   <= zs;
            pxyd_reg <= pxys;
            rd_reg   <= sq_root + RAD_W'(sq_rem > {1'b0, sq_root});
        end
    end

    // ---------------------------------------------------------------
    // rho = floor(sqrt((x^2+y^2) * 2^20)): 28 stages, 10 fraction bits
    // ---------------------------------------------------------------
    localparam int RHO_SIDE_W = 3 * COORD_W + RAD_W;

    logic                      rho_valid;
    logic [RHO_W-1:0]          rho;
    logic [RHO_SIDE_W-1:0]     rho_side;
    logic signed [COORD_W-1:0] xr;
    logic signed [COORD_W-1:0] yr;
    logic signed [COORD_W-1:0] zr;
    logic [RAD_W-1:0]          rr;

    c2s_isqrt #(
        .IN_W   (RHO_IN_W),
        .SIDE_W (RHO_SIDE_W)
    ) u_rho_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vd_reg),
        .radicand  ({pxyd_reg, {RHO_SHIFT{1'b0}}}),
        .in_side   ({xd_reg, yd_reg, zd_reg, rd_reg}),
        .out_valid (rho_valid),
        .root      (rho),
        .rem       (),
        .out_side  (rho_side)
    );

    assign {xr, yr, zr, rr} = rho_side;

    // ---------------------------------------------------------------
    // Two identical angle units run in lockstep.
    // theta = atan2(rho, z * 2^10); rho >= 0 so theta lands in 0..pi.
    // At the origin both operands are zero and the unit returns 0.
    // phi = atan2(y, x); negative x on the axis gives +half turn.
    // ---------------------------------------------------------------
    logic                    theta_valid;
    logic signed [PHI_W-1:0] theta_angle;
    logic [RAD_W-1:0]        theta_side;
    logic                    phi_valid;
    logic signed [PHI_W-1:0] phi_angle;
    logic signed [ANG_IN_W-1:0] th_a;
    logic signed [ANG_IN_W-1:0] th_b;
    logic signed [ANG_IN_W-1:0] ph_a;
    logic signed [ANG_IN_W-1:0] ph_b;

    assign th_a = {{(ANG_IN_W-COORD_W-Z_SHIFT){zr[COORD_W-1]}}, zr, {Z_SHIFT{1'b0}}};
    assign th_b = {{(ANG_IN_W-RHO_W){1'b0}}, rho};
    assign ph_a = {{(ANG_IN_W-COORD_W){xr[COORD_W-1]}}, xr};
    assign ph_b = {{(ANG_IN_W-COORD_W){yr[COORD_W-1]}}, yr};

    c2s_cordic #(
        .SIDE_W (RAD_W)
    ) u_theta (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rho_valid),
        .a         (th_a),
        .b         (th_b),
        .in_side   (rr),
        .out_valid (theta_valid),
        .angle     (theta_angle),
        .out_side  (theta_side)
    );

    c2s_cordic #(
        .SIDE_W (1)
    ) u_phi (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rho_valid),
        .a         (ph_a),
        .b         (ph_b),
        .in_side   (1'b0),
        .out_valid (phi_valid),
        .angle     (phi_angle),
        .out_side  ()
    );

    // last stage of the angle units is the output register
    assign out_valid   = theta_valid;
    assign radius      = theta_side;
    assign polar_angle = theta_angle[THETA_W-1:0];
    assign azimuth     = phi_angle;

`ifndef NO_ASSERTIONS
    // both angle units must stay in lockstep
    a_lanes_aligned : assert property (@(posedge clk) disable iff (!rst_n)
        phi_valid == theta_valid)
        else $error("angle units out of step");

    // zero radius only at the origin, where both angles are zero
    a_origin : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (radius == '0) |-> (polar_angle == '0) && (azimuth == '0))
        else $error("nonzero angle at the origin");

    // theta never exceeds a half turn
    a_theta_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> polar_angle <= THETA_W'(HALF_TURN))
        else $error("polar angle out of range");
`endif

endmodule

`default_nettype wire

// File: tb/c2s_scoreboard.sv
`timescale 1ns / 100ps

// Bit-exact predictor of the spherical conversion plus a queue of pending points.
class c2s_scoreboard;

    typedef struct {
        logic [17:0] radius;
        logic [15:0] polar_angle;
        logic [16:0] azimuth;
    } sph_point_t;

    sph_point_t        pending_points[$];
    int                errors;
    longint            atan_rad[40];

    function new();
        errors = 0;
        atan_rad[0] = atan_of_recip(2) + atan_of_recip(3);
        for (int i = 1; i < 40; i++)
            atan_rad[i] = atan_of_recip(longint'(1) << i);
    endfunction

    // atan(1/n) * 2^40 by the truncated odd series
    function longint atan_of_recip(longint unsigned n);
        longint unsigned p;
        longint unsigned term;
        longint          sum;
        longint unsigned k;
        p   = (64'd1 << 40) / n;
        sum = longint'(p);
        k   = 1;
        forever
        begin
            p = p / n / n;
            if (p == 0)
                break;
            term = p / (2 * k + 1);
            if (k[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
            k++;
        end
        return sum;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function int first_quadrant(longint unsigned ua, longint unsigned ub);
        longint unsigned m;
        longint unsigned u;
        longint unsigned q;
        longint          cx;
        longint          cy;
        longint          acc;
        longint          dx;
        longint          dy;
        longint          lim;
        int              s;
        m   = (ua > ub) ? ua : ub;
        s   = 0;
        acc = 0;
        if (m == 0)
            return 0;
        while (m < (64'd1 << 40))
        begin
            m = m << 1;
            s++;
        end
        cx = longint'(ua << s);
        cy = longint'(ub << s);
        for (int i = 0; i < 40; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx  = cx + dx;
                cy  = cy - dy;
                acc = acc + atan_rad[i];
            end
            else
            begin
                cx  = cx - dx;
                cy  = cy + dy;
                acc = acc - atan_rad[i];
            end
        end
        lim = 2 * atan_rad[0];
        if (acc < 0)
            acc = 0;
        if (acc > lim)
            acc = lim;
        u = longint'(unsigned'(acc)) >> 8;
        u = longint'(unsigned'(acc)) >> 8;
        q = (u * 64'd683565276 + (64'd1 << 47)) >> 48;
        if (q > 16384)
            q = 16384;
        return int'(q);
    endfunction

    function int full_angle(longint a, longint b);
        int q;
        q = first_quadrant(a < 0 ? -a : a, b < 0 ? -b : b);
        if (a >= 0)
            return (b >= 0) ? q : -q;
        return (b >= 0) ? (32768 - q) : -(32768 - q);
    endfunction

    function void note_point(logic signed [17:0] px, logic signed [17:0] py,
                             logic signed [17:0] pz);
        longint          x;
        longint          y;
        longint          z;
        longint unsigned pxy;
        longint unsigned s;
        longint unsigned r;
        longint unsigned rho;
        int              theta;
        int              phi;
        sph_point_t      e;
        x     = px;
        y     = py;
        z     = pz;
        theta = 0;
        pxy   = x * x + y * y;
        s     = pxy + z * z;
        r     = int_sqrt(s);
        if (s - r * r > r)
            r++;
        if (s != 0)
        begin
            rho   = int_sqrt(pxy << 20);
            theta = full_angle(z * 1024, longint'(rho));
        end
        phi           = full_angle(x, y);
        e.radius      = r[17:0];
        e.polar_angle = theta[15:0];
        e.azimuth     = phi[16:0];
        pending_points.push_back(e);
    endfunction

    function void check_point(logic [17:0] r, logic [15:0] t, logic [16:0] a);
        sph_point_t e;
        if (pending_points.size() == 0)
        begin
            $display("%0t: output beat with nothing pending: r=%0d t=%0d a=%0d",
                     $time, r, t, $signed(a));
            errors++;
            return;
        end
        e = pending_points.pop_front();
        if (r !== e.radius)
        begin
            $display("%0t: radius expected %0d actual %0d", $time, e.radius, r);
            errors++;
        end
        if (t !== e.polar_angle)
        begin
            $display("%0t: polar_angle expected %0d actual %0d", $time, e.polar_angle, t);
            errors++;
        end
        if (a !== e.azimuth)
        begin
            $display("%0t: azimuth expected %0d actual %0d", $time,
                     $signed(e.azimuth), $signed(a));
            errors++;
        end
    endfunction

endclass

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import c2s_pkg::*;

    localparam int STALL_LIMIT  = 20000;  // cycles with no beat on either side
    localparam int HOLDOFF_LEN  = 400;    // long receiver hold-off, well past pipe depth
    localparam int DRAIN_CYCLES = 150;    // extra wait once nothing is pending
    localparam int RAND_PER_PHASE = 480;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      out_valid;
    logic                      out_stall;
    logic [RAD_W-1:0]          radius;
    logic [THETA_W-1:0]        polar_angle;
    logic signed [PHI_W-1:0]   azimuth;

    c2s_scoreboard sb;

    // idle percentages for each side, changed per phase
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  holdoff_req;
    int  quiet_cycles;

    cartesian_to_spherical_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .radius      (radius),
        .polar_angle (polar_angle),
        .azimuth     (azimuth)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Input beats are noted, output beats checked, both at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_point(radius, polar_angle, azimuth);
    end

    // Watchdog: any beat on either side restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("** cartesian_to_spherical_core: FAILED **");
            $finish;
        end
    end

    // Receiver: random stalls, or one long hold-off on request so the pipe
    // fills and pushes back on the input side.
    initial
    begin
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holdoff_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLDOFF_LEN) @(negedge clk);
                holdoff_req = 1'b0;
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // One input beat; entered and left at a falling edge.
    task automatic send_point(logic signed [17:0] x, logic signed [17:0] y,
                              logic signed [17:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        coord_x  <= x;
        coord_y  <= y;
        coord_z  <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_point(x, y, z);
        @(negedge clk);
    endtask

    function automatic logic signed [17:0] rand_coord(int mode);
        case (mode)
            0: return 18'($urandom);
            1: return 18'($signed($urandom_range(64)) - 32);
            2: return ($urandom_range(1)) ? 18'sh1FFFF : -18'sh20000;
            default: return 18'sh0;
        endcase
    endfunction

    task automatic send_directed();
        send_point(0, 0, 0);                          // origin
        send_point(0, 0, 5);                          // +z axis
        send_point(0, 0, -5);                         // -z axis
        send_point(0, 0, 131071);
        send_point(0, 0, -131072);
        send_point(-7, 0, 3);                         // negative x with y = 0
        send_point(-131072, 0, 0);
        send_point(131071, 0, 0);
        send_point(0, 131071, 0);
        send_point(0, -131072, 0);
        send_point(-131072, -131072, -131072);        // largest radius
        send_point(131071, 131071, 131071);
        send_point(-131072, 131071, -131072);
        send_point(131071, -131072, 131071);
        send_point(1, 1, 1);
        send_point(-1, 1, 0);
        send_point(-1, -1, 0);
        send_point(1, -1, 0);
        send_point(3, 4, 0);
        send_point(100, 100, -100);
    endtask

    task automatic send_random(int count);
        int mx;
        int my;
        int mz;
        for (int i = 0; i < count; i++)
        begin
            // mostly full range, with small values, extremes and axis points mixed in
            mx = ($urandom_range(99) < 60) ? 0 : $urandom_range(3);
            my = ($urandom_range(99) < 60) ? 0 : $urandom_range(3);
            mz = ($urandom_range(99) < 60) ? 0 : $urandom_range(3);
            send_point(rand_coord(mx), rand_coord(my), rand_coord(mz));
        end
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        coord_x       = '0;
        coord_y       = '0;
        coord_z       = '0;
        holdoff_req   = 1'b0;
        quiet_cycles  = 0;
        send_idle_pct = 14;
        recv_idle_pct = 81;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_directed();
        send_random(RAND_PER_PHASE);

        send_idle_pct = 81;
        recv_idle_pct = 14;
        send_directed();
        send_random(RAND_PER_PHASE);

        // no idling; one long hold-off while the sender keeps going
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(50);
        holdoff_req = 1'b1;
        send_random(RAND_PER_PHASE - 50);
        in_valid <= 1'b0;

        while (sb.pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("** cartesian_to_spherical_core: PASSED **");
        else
            $display("** cartesian_to_spherical_core: FAILED **");
        $finish;
    end

endmodule

// File: files.f
design/c2s_pkg.sv
design/c2s_isqrt.sv
design/c2s_cordic.sv
design/cartesian_to_spherical_core.sv
tb/c2s_scoreboard.sv
tb/tb_top.sv
